[src/oqr_pkg.sv]
package oqr_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_POP    = 2'd2
  } action_t;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   popped_value;
    logic [COUNT_W-1:0]   entry_count;
  } result_t;

endpackage

[src/oqr_mem.sv]
module oqr_mem import oqr_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/oqr_ctrl.sv]
module oqr_ctrl import oqr_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [1:0]         cmd_action,
  input  logic [VALUE_W-1:0] cmd_value,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [VALUE_W-1:0] mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [VALUE_W-1:0] mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SEARCH  = 5'b00010,
    S_COMPACT = 5'b00100,
    S_POP     = 5'b01000,
    S_RESP    = 5'b10000
  } state_t;

  localparam logic [AW-1:0] LAST_PTR = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST_PTR : p - AW'(1);
  endfunction

  state_t             state_r,  state_nxt;
  logic [AW-1:0]      head_r,   head_nxt;
  logic [AW-1:0]      tail_r,   tail_nxt;
  logic [CW-1:0]      total_r,  total_nxt;
  logic [AW-1:0]      ptr_r,    ptr_nxt;
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]      left_r,   left_nxt;
  logic [CW-1:0]      mv_r,     mv_nxt;
  logic [VALUE_W-1:0] key_r,    key_nxt;
  status_t            status_r, status_nxt;
  logic [VALUE_W-1:0] popped_r, popped_nxt;
  logic [CW+COUNT_W-1:0] total_ext;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    total_nxt  = total_r;
    ptr_nxt    = ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    left_nxt   = left_r;
    mv_nxt     = mv_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    mem_we     = 1'b0;
    mem_waddr  = wr_ptr_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          key_nxt    = cmd_value;
          status_nxt = ST_OK;
          popped_nxt = '0;
          state_nxt  = S_RESP;
          unique case (action_t'(cmd_action))
            ACT_INSERT: begin
              if (total_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                mem_wdata = cmd_value;
                tail_nxt  = ptr_inc(tail_r);
                total_nxt = total_r + CW'(1);
              end
            end
            ACT_REMOVE: begin
              if (total_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ptr_dec(tail_r);
                ptr_nxt   = ptr_dec(tail_r);
                left_nxt  = total_r;
                state_nxt = S_SEARCH;
              end
            end
            ACT_POP: begin
              if (total_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // newest to oldest, one entry per cycle
        if (mem_rdata == key_r) begin
          if (left_r == total_r) begin
            tail_nxt  = ptr_dec(tail_r);
            total_nxt = total_r - CW'(1);
            state_nxt = S_RESP;
          end else begin
            wr_ptr_nxt = ptr_r;
            ptr_nxt    = ptr_inc(ptr_r);
            mem_re     = 1'b1;
            mem_raddr  = ptr_inc(ptr_r);
            mv_nxt     = total_r - left_r;
            state_nxt  = S_COMPACT;
          end
        end else if (left_r == CW'(1)) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          ptr_nxt   = ptr_dec(ptr_r);
          mem_re    = 1'b1;
          mem_raddr = ptr_dec(ptr_r);
          left_nxt  = left_r - CW'(1);
        end
      end
      S_COMPACT: begin
        // move each newer entry down one slot
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_r;
        mem_wdata = mem_rdata;
        if (mv_r == CW'(1)) begin
          tail_nxt  = ptr_dec(tail_r);
          total_nxt = total_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          wr_ptr_nxt = ptr_r;
          ptr_nxt    = ptr_inc(ptr_r);
          mem_re     = 1'b1;
          mem_raddr  = ptr_inc(ptr_r);
          mv_nxt     = mv_r - CW'(1);
        end
      end
      S_POP: begin
        popped_nxt = mem_rdata;
        head_nxt   = ptr_inc(head_r);
        total_nxt  = total_r - CW'(1);
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
    left_r   <= left_nxt;
    mv_r     <= mv_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  assign total_ext        = {{COUNT_W{1'b0}}, total_r};
  assign cmd_ready        = (state_r == S_IDLE);
  assign res_valid        = (state_r == S_RESP);
  assign res.status       = status_r;
  assign res.popped_value = popped_r;
  assign res.entry_count  = total_ext[COUNT_W-1:0];

endmodule

[src/ordered_queue_with_remove_by_value.sv]
// Ordered value queue with remove by value.
// Input channel in_*: in_tuser carries the action (insert newest, remove the
// newest entry equal to the value, pop oldest), in_tdata the 32-bit value.
// Output channel out_*: one transaction per input transaction, carrying
// status, the popped value (zero unless a pop succeeded) and the entry count
// after the operation (modulo 128).
// Entries live in a CAPACITY-deep single-read-port memory used as a ring.
// Steps from accept to out_tvalid: insert, refused and unused actions go
// through the response state to the output register, pop first reads the
// oldest entry, remove first searches entries and then moves the newer
// ones down. One item is worked on at a time; the next is accepted the
// cycle after the result enters the output register. Remove time is set by
// the one-entry per cycle memory read during the search and the compaction.
// Reset (synchronous, rst_n low) empties the queue; memory contents are not
// cleared and no startup pass is needed.
// When out_tready is low the result waits in the output register; the next
// item is still accepted and worked on, and waits for the register to free.
module ordered_queue_with_remove_by_value import oqr_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], popped_value[33:2], entry_count[40:34]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [47:0]        out_tdata_r,  out_tdata_nxt;

  oqr_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  oqr_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_tvalid),
    .cmd_ready  (in_tready),
    .cmd_action (in_tuser),
    .cmd_value  (in_tdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // output register
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_ready) begin
      out_tvalid_nxt = res_valid;
      if (res_valid) begin
        out_tdata_nxt = {7'd0, res.entry_count, res.popped_value, res.status};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[src/oqr_chk.sv]
module oqr_chk import oqr_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(CAPACITY % 128);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // popped value only on a successful operation
  a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[33:2] != 32'd0) |-> out_tdata[1:0] == ST_OK)
    else $error("popped value with non-ok status");

  // empty status only with zero count
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_EMPTY) |-> out_tdata[40:34] == 7'd0)
    else $error("empty status with entries stored");

  // full status only with a full count
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_FULL) |-> out_tdata[40:34] == FULL_CNT)
    else $error("full status with free entries");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ordered_queue_with_remove_by_value oqr_chk #(.CAPACITY(CAPACITY)) u_chk (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import oqr_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 800;
  localparam int QUIET_FROM = 700;
  localparam int PHASE_LEN = 150;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
  localparam int MAX_REPORTS = 50;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] val;
    bit          typed;
    result_t     res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // value[31:0]
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // status[1:0], popped_value[33:2], entry_count[40:34]

  logic [31:0] shadow_entries[$];
  result_t     pending_results[$];
  bit          gaps_on = 1'b1;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          peak_fill = 0;
  int          op_tally[4][4];

  result_t     want;
  logic [1:0]  act;
  logic [31:0] val;
  int          n;
  int          phase;
  int          r;

  stim_row_t directed_rows[23] = '{
    '{ACT_POP,    32'h0,        1'b1, '{ST_EMPTY,     32'h0,        7'd0}},
    '{ACT_REMOVE, 32'h0,        1'b1, '{ST_EMPTY,     32'h0,        7'd0}},
    '{ACT_UNUSED, 32'hFFFFFFFF, 1'b1, '{ST_OK,        32'h0,        7'd0}},
    '{ACT_INSERT, 32'h80000000, 1'b1, '{ST_OK,        32'h0,        7'd1}},
    '{ACT_INSERT, 32'h7FFFFFFF, 1'b1, '{ST_OK,        32'h0,        7'd2}},
    '{ACT_INSERT, 32'hFFFFFFFF, 1'b1, '{ST_OK,        32'h0,        7'd3}},
    '{ACT_INSERT, 32'h00000000, 1'b1, '{ST_OK,        32'h0,        7'd4}},
    '{ACT_INSERT, 32'h7FFFFFFF, 1'b1, '{ST_OK,        32'h0,        7'd5}},
    '{ACT_REMOVE, 32'h12345678, 1'b1, '{ST_NOT_FOUND, 32'h0,        7'd5}},
    '{ACT_REMOVE, 32'h7FFFFFFF, 1'b1, '{ST_OK,        32'h0,        7'd4}},
    '{ACT_UNUSED, 32'h55555555, 1'b1, '{ST_OK,        32'h0,        7'd4}},
    '{ACT_POP,    32'h0,        1'b1, '{ST_OK,        32'h80000000, 7'd3}},
    '{ACT_POP,    32'h0,        1'b0, NO_RES},
    '{ACT_INSERT, 32'hAAAAAAAA, 1'b0, NO_RES},
    '{ACT_INSERT, 32'h55555555, 1'b0, NO_RES},
    '{ACT_REMOVE, 32'hFFFFFFFF, 1'b0, NO_RES},
    '{ACT_REMOVE, 32'h00000000, 1'b0, NO_RES},
    '{ACT_INSERT, 32'h00000001, 1'b0, NO_RES},
    '{ACT_REMOVE, 32'h00000001, 1'b0, NO_RES},
    '{ACT_POP,    32'h0,        1'b0, NO_RES},
    '{ACT_POP,    32'h0,        1'b0, NO_RES},
    '{ACT_POP,    32'h0,        1'b0, NO_RES},
    '{ACT_REMOVE, 32'h55555555, 1'b0, NO_RES}
  };

  ordered_queue_with_remove_by_value #(.CAPACITY(CAPACITY)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("tb NOT OK");
    $finish;
  end

  // queue behavior: index 0 is the oldest entry
  function automatic result_t apply_queue_op(input logic [1:0] op, input logic [31:0] v);
    result_t res;
    int      hit;
    res.status = ST_OK;
    res.popped_value = '0;
    hit = -1;
    case (op)
      ACT_INSERT: begin
        if (shadow_entries.size() >= CAPACITY) res.status = ST_FULL;
        else shadow_entries.push_back(v);
      end
      ACT_REMOVE: begin
        if (shadow_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int i = shadow_entries.size() - 1; i >= 0 && hit < 0; i--)
            if (shadow_entries[i] == v) hit = i;
          if (hit < 0) res.status = ST_NOT_FOUND;
          else shadow_entries.delete(hit);
        end
      end
      ACT_POP: begin
        if (shadow_entries.size() == 0) res.status = ST_EMPTY;
        else res.popped_value = shadow_entries.pop_front();
      end
      default: ;
    endcase
    res.entry_count = 7'(shadow_entries.size());
    return res;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] extremes[4] = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0};
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 32'($urandom_range(0, 7));
    if (sel == 4) return extremes[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on result %0d, %s: expected %0h, got %0h",
               results_seen, what, exp_v, got_v);
  endtask

  // one input transaction; valid stays high into the next call unless a gap is taken
  task automatic send_op(input logic [1:0] op, input logic [31:0] v, input bit typed,
                         input result_t typed_res);
    result_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    predicted = apply_queue_op(op, v);
    pending_results.push_back(typed ? typed_res : predicted);
    op_tally[op][predicted.status]++;
    if (shadow_entries.size() > peak_fill) peak_fill = shadow_entries.size();
    @(negedge clk);
  endtask

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 11) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", '0, 32'(out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_tdata[1:0]));
        if (out_tdata[33:2] !== want.popped_value)
          report_mismatch("popped_value", want.popped_value, out_tdata[33:2]);
        if (out_tdata[40:34] !== want.entry_count)
          report_mismatch("entry_count", 32'(want.entry_count), 32'(out_tdata[40:34]));
      end
      results_seen++;
    end
  end

  initial begin
    foreach (op_tally[i, j]) op_tally[i][j] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k])
      send_op(directed_rows[k].act, directed_rows[k].val, directed_rows[k].typed,
              directed_rows[k].res);

    // phases: grow to full, churn around the middle, shrink to empty
    n = 0;
    while (n < RANDOM_OPS) begin
      phase = (n / PHASE_LEN) % 3;
      gaps_on = (n < QUIET_FROM);
      r = $urandom_range(0, 99);
      case (phase)
        0:       act = (r < 85) ? ACT_INSERT : (r < 93) ? ACT_REMOVE : (r < 97) ? ACT_POP
                                                                                 : ACT_UNUSED;
        1:       act = (r < 40) ? ACT_INSERT : (r < 75) ? ACT_REMOVE : (r < 97) ? ACT_POP
                                                                                 : ACT_UNUSED;
        default: act = (r < 15) ? ACT_INSERT : (r < 60) ? ACT_REMOVE : (r < 97) ? ACT_POP
                                                                                 : ACT_UNUSED;
      endcase
      if (act == ACT_REMOVE && shadow_entries.size() != 0 && $urandom_range(0, 9) < 7)
        val = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      else
        val = pick_value();
      send_op(act, val, 1'b0, NO_RES);
      if (act != ACT_UNUSED) n++;
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("inserts %0d (refused full %0d), removes %0d (not found %0d, on empty %0d)",
             op_tally[ACT_INSERT][ST_OK], op_tally[ACT_INSERT][ST_FULL],
             op_tally[ACT_REMOVE][ST_OK], op_tally[ACT_REMOVE][ST_NOT_FOUND],
             op_tally[ACT_REMOVE][ST_EMPTY]);
    $display("pops %0d (on empty %0d), unused actions %0d, peak fill %0d of %0d, %0d mismatches",
             op_tally[ACT_POP][ST_OK], op_tally[ACT_POP][ST_EMPTY],
             op_tally[ACT_UNUSED][ST_OK], peak_fill, CAPACITY, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
